/* sv/ftd_pkg.sv */
// Shared types and constants of the task dispatcher.
package ftd_pkg;

    // Task table depth; ids must fit in TID_W bits.
    localparam int NUM_TASKS = 8;
    localparam int TID_W     = 3;
    localparam int IN_TID_W  = 4;
    localparam int PTR_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    localparam logic [TID_W-1:0] IDLE_RESET = TID_W'(7);

    typedef logic [TID_W-1:0] tid_t;

    typedef enum logic [1:0] {
        OP_ACTIVATE    = 2'd0,
        OP_TERMINATE   = 2'd1,
        OP_TICK        = 2'd2,
        OP_SWITCH_DONE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_SUSPENDED = 2'd0,
        ST_READY     = 2'd1,
        ST_RUNNING   = 2'd2,
        ST_WAITING   = 2'd3
    } task_state_t;

    // Ready ring control and status
    typedef struct packed {
        logic push;
        tid_t push_id;
        logic pop;
    } ring_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        tid_t head_id;
    } ring_stat_t;

    // Task table updates (at most one write per task per cycle)
    typedef struct packed {
        tid_t act_id;     // lookup and ready-write id
        logic act_en;
        tid_t susp_id;
        logic susp_en;
        tid_t run_id;     // lookup and running-write id
        logic run_en;
    } tbl_cmd_t;

    typedef struct packed {
        logic act_free;   // act_id is suspended or waiting
        logic run_ready;  // run_id is ready
    } tbl_stat_t;

endpackage

/* sv/fifo_task_dispatcher_top.sv */
// Top level of the task dispatcher: request register, decision logic, result register.
// Usage:
//   Requests enter on the in channel (valid/ready): opcode and task_id.
//   Opcodes: activate, terminate current, tick, context switch done.
//   Each request gives exactly one result on the out channel (valid/ready):
//   status, switch_request and a snapshot of the pending (next) and current
//   task registers after the request took effect.
//   The idle task id is written on the cfg channel (cfg_valid/cfg_ready,
//   cfg_data); cfg_ready is always high. Write it only while no request is
//   in flight.
// Flow and throughput:
//   An accepted request is captured in the request register; once the result slot
//   is free or draining, its result is registered (out_valid high until taken).
//   One request per cycle is sustained while results are taken: the state
//   update is a single pass of table lookup plus at most one ring push or pop.
// Reset: all tasks suspended, ring empty, no current task, no ticket, idle id 7.
//   Ring storage is not cleared; it is written before read.
// Back-pressure:
//   While out_ready is low a result is held; one more request may wait in the
//   request register, then in_ready drops until the result is taken.
module fifo_task_dispatcher_top
    import ftd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [IN_TID_W-1:0] task_id,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic                status,
    output logic                switch_request,
    output logic [TID_W-1:0]    next_task,
    output logic                next_valid,
    output logic [TID_W-1:0]    current_task,
    output logic                current_valid,
    // idle task register
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [TID_W-1:0]    cfg_data
);

    // Request register
    logic                req_valid_reg;
    logic                req_valid_next;
    opcode_t             op_reg;
    logic [IN_TID_W-1:0] tid_reg;

    // Dispatcher state
    tid_t idle_reg;
    tid_t cur_id_reg;
    tid_t cur_id_next;
    logic cur_valid_reg;
    logic cur_valid_next;
    tid_t pend_id_reg;
    tid_t pend_id_next;
    logic pend_valid_reg;
    logic pend_valid_next;

    // Result register
    logic out_valid_reg;
    logic out_valid_next;
    logic status_reg;
    logic sw_reg;
    tid_t next_task_reg;
    logic next_valid_reg;
    tid_t cur_task_reg;
    logic cur_valid_out_reg;

    // Decision signals
    logic       adv;
    logic       status_c;
    logic       sw_c;
    logic       bad_id;
    logic       act_ok;
    logic       do_disp;
    logic       pop_ok;
    ring_cmd_t  ring_cmd;
    ring_stat_t ring_stat;
    tbl_cmd_t   tbl_cmd;
    tbl_stat_t  tbl_stat;

    ftd_ring u_ring (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (ring_cmd),
        .stat (ring_stat)
    );

    ftd_task_table u_table (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (tbl_cmd),
        .stat (tbl_stat)
    );

    // Process the held request when the result slot is free or draining.
    assign adv       = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !req_valid_reg || adv;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (adv)
            req_valid_next = 1'b0;
        if (in_valid && in_ready)
            req_valid_next = 1'b1;
    end

    assign bad_id = (tid_reg >= IN_TID_W'(NUM_TASKS)) ||
                    (tid_reg == {1'b0, idle_reg});
    assign act_ok = adv && (op_reg == OP_ACTIVATE) && !bad_id && tbl_stat.act_free;

    always_comb
    begin
        status_c        = 1'b0;
        sw_c            = 1'b0;
        do_disp         = 1'b0;
        pop_ok          = 1'b0;
        cur_id_next     = cur_id_reg;
        cur_valid_next  = cur_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_valid_next = pend_valid_reg;

        tbl_cmd.act_id  = tid_reg[TID_W-1:0];
        tbl_cmd.act_en  = act_ok;
        tbl_cmd.susp_id = cur_id_reg;
        tbl_cmd.susp_en = 1'b0;
        tbl_cmd.run_id  = ring_stat.head_id;
        tbl_cmd.run_en  = 1'b0;

        ring_cmd.push    = 1'b0;
        ring_cmd.push_id = tid_reg[TID_W-1:0];
        ring_cmd.pop     = 1'b0;

        if (adv)
        begin
            unique case (op_reg)
                OP_ACTIVATE:
                begin
                    status_c = bad_id;
                    if (act_ok)
                    begin
                        ring_cmd.push = 1'b1;
                        if (!cur_valid_reg)
                        begin
                            cur_id_next    = tid_reg[TID_W-1:0];
                            cur_valid_next = 1'b1;
                        end
                        // idle running and no ticket: ask for a switch
                        sw_c = cur_valid_reg && (cur_id_reg == idle_reg) && !pend_valid_reg;
                    end
                end
                OP_TERMINATE:
                begin
                    tbl_cmd.susp_en = cur_valid_reg &&
                                      ({1'b0, cur_id_reg} < (TID_W + 1)'(NUM_TASKS));
                    do_disp = 1'b1;
                end
                OP_TICK:
                    do_disp = !pend_valid_reg && cur_valid_reg && (cur_id_reg == idle_reg);
                OP_SWITCH_DONE:
                begin
                    if (pend_valid_reg)
                    begin
                        cur_id_next     = pend_id_reg;
                        cur_valid_next  = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                end
            endcase

            // Schedule: pop the ring, fall back to idle
            if (do_disp && !pend_valid_reg)
            begin
                ring_cmd.pop = !ring_stat.empty;
                // a task suspended by this same request is no longer ready
                pop_ok = !ring_stat.empty && tbl_stat.run_ready &&
                         !(tbl_cmd.susp_en && (ring_stat.head_id == cur_id_reg));
                tbl_cmd.run_en  = pop_ok;
                pend_id_next    = pop_ok ? ring_stat.head_id : idle_reg;
                pend_valid_next = 1'b1;
                sw_c            = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (adv)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            idle_reg       <= IDLE_RESET;
            cur_id_reg     <= '0;
            cur_valid_reg  <= 1'b0;
            pend_id_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg  <= req_valid_next;
            out_valid_reg  <= out_valid_next;
            cur_id_reg     <= cur_id_next;
            cur_valid_reg  <= cur_valid_next;
            pend_id_reg    <= pend_id_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_valid && cfg_ready)
                idle_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= opcode_t'(opcode);
            tid_reg <= task_id;
        end
        if (adv)
        begin
            status_reg        <= status_c;
            sw_reg            <= sw_c;
            next_task_reg     <= pend_id_next;
            next_valid_reg    <= pend_valid_next;
            cur_task_reg      <= cur_id_next;
            cur_valid_out_reg <= cur_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign switch_request = sw_reg;
    assign next_task      = next_task_reg;
    assign next_valid     = next_valid_reg;
    assign current_task   = cur_task_reg;
    assign current_valid  = cur_valid_out_reg;

    // A rejected activate never requests a switch.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && status_c) |-> !sw_c)
        else $error("switch requested on rejected activate");

    // Once a current task exists it never goes away.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(cur_valid_reg))
        else $error("current task lost");

    // A pending ticket stays put until switch done.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && pend_valid_reg && (op_reg != OP_SWITCH_DONE)) |=>
            (pend_valid_reg && (pend_id_reg == $past(pend_id_reg))))
        else $error("pending ticket changed");

    // Push and pop never come from the same request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ring_cmd.push && ring_cmd.pop))
        else $error("ring push and pop together");

endmodule

/* sv/ftd_ring.sv */
// Ready ring: FIFO of task ids with one slot kept empty.
module ftd_ring
    import ftd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ring_cmd_t  cmd,
    output ring_stat_t stat
);

    tid_t             ring_mem [NUM_TASKS];
    tid_t             head_id_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [PTR_W-1:0] tail_inc;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(NUM_TASKS - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign tail_inc     = ptr_inc(tail_reg);
    assign stat.empty   = (head_reg == tail_reg);
    assign stat.full    = (tail_inc == head_reg);
    assign stat.head_id = head_id_reg;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (cmd.pop && !stat.empty)
            head_next = ptr_inc(head_reg);
        if (cmd.push && !stat.full)
            tail_next = tail_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Storage, no reset; head entry is read ahead for the next cycle
    always_ff @(posedge clk)
    begin
        if (cmd.push && !stat.full)
            ring_mem[tail_reg] <= cmd.push_id;
        // write-through when the new head slot is the one written now
        if (cmd.push && !stat.full && (tail_reg == head_next))
            head_id_reg <= cmd.push_id;
        else
            head_id_reg <= ring_mem[head_next];
    end

endmodule

/* sv/ftd_task_table.sv */
// Per-task state table, one lane of state per task.
module ftd_task_table
    import ftd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tbl_cmd_t  cmd,
    output tbl_stat_t stat
);

    task_state_t          state_reg  [NUM_TASKS];
    task_state_t          state_next [NUM_TASKS];
    logic [NUM_TASKS-1:0] act_hit;
    logic [NUM_TASKS-1:0] run_hit;
    logic [NUM_TASKS-1:0] susp_hit;
    logic [NUM_TASKS-1:0] free_vec;
    logic [NUM_TASKS-1:0] ready_vec;

    for (genvar i = 0; i < NUM_TASKS; i++)
    begin : g_lane
        assign act_hit[i]   = (cmd.act_id  == TID_W'(i));
        assign run_hit[i]   = (cmd.run_id  == TID_W'(i));
        assign susp_hit[i]  = (cmd.susp_id == TID_W'(i));
        assign free_vec[i]  = (state_reg[i] == ST_SUSPENDED) ||
                              (state_reg[i] == ST_WAITING);
        assign ready_vec[i] = (state_reg[i] == ST_READY);

        always_comb
        begin
            state_next[i] = state_reg[i];
            priority if (cmd.susp_en && susp_hit[i])
                state_next[i] = ST_SUSPENDED;
            else if (cmd.run_en && run_hit[i])
                state_next[i] = ST_RUNNING;
            else if (cmd.act_en && act_hit[i])
                state_next[i] = ST_READY;
            else
                state_next[i] = state_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                state_reg[i] <= ST_SUSPENDED;
            else
                state_reg[i] <= state_next[i];
        end
    end

    assign stat.act_free  = |(free_vec & act_hit);
    assign stat.run_ready = |(ready_vec & run_hit);

endmodule
